>>> hdl/i2c_master_bit_engine_core_defines.svh
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared property wrappers clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication
`define I2CBE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define I2CBE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, register indexes, reset values and the sequencer phase type.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

   // Widths
   localparam int unsigned CSR_IDX_W       = 3;
   localparam int unsigned CSR_DATA_W      = 16;
   localparam int unsigned DELAY_BITS_DFLT = 16;

   // Command kinds
   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_US  = 3'd0,
      CSR_COND_HOLD_US  = 3'd1,
      CSR_WR_SETUP_US   = 3'd2,
      CSR_WR_HIGH_US    = 3'd3,
      CSR_WR_AFTER_US   = 3'd4,
      CSR_RD_RELEASE_US = 3'd5,
      CSR_RD_HIGH_US    = 3'd6,
      CSR_RD_AFTER_US   = 3'd7
   } csr_idx_type;

   // Register reset values
   localparam logic [7:0]  RST_TICKS_PER_US  = 8'd16;
   localparam logic [15:0] RST_COND_HOLD_US  = 16'd5;
   localparam logic [15:0] RST_WR_SETUP_US   = 16'd3;
   localparam logic [15:0] RST_WR_HIGH_US    = 16'd5;
   localparam logic [15:0] RST_WR_AFTER_US   = 16'd3;
   localparam logic [15:0] RST_RD_RELEASE_US = 16'd5;
   localparam logic [15:0] RST_RD_HIGH_US    = 16'd20;
   localparam logic [15:0] RST_RD_AFTER_US   = 16'd5;

   // Bits per byte element: eight data bits plus the acknowledge bit
   localparam logic [3:0] LAST_DATA_BIT = 4'd7;
   localparam logic [3:0] ACK_BIT_IDX   = 4'd8;

   // Sequencer phases
   typedef enum logic [6:0] {
      PH_IDLE  = 7'b000_0001,
      PH_C0    = 7'b000_0010,
      PH_C1    = 7'b000_0100,
      PH_C2    = 7'b000_1000,
      PH_BSET  = 7'b001_0000,
      PH_BHIGH = 7'b010_0000,
      PH_BLOW  = 7'b100_0000
   } phase_type;

endpackage

>>> hdl/i2c_master_bit_engine_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Single-master I2C sequencer for start, stop, write byte and read byte.
// ----------------------------------------------------------------------------
// Each item on the req channel is one clock tick of the bus sequencer: it
// carries the command offer (cmd_valid, kind, tx_byte, send_ack) and the
// sampled SDA level. Each accepted item yields exactly one rsp item with the
// SCL/SDA drives, busy, the done pulse, the last read byte and the last
// acknowledge bit, all as they stand after that tick.
// Throughput is one item per cycle while req_tready is high. The rsp item
// is registered, in the skid entry if the output register is held. The
// sequencer state and the rsp register update together, so the tick path
// is one prescale compare, one wait decrement and the phase selection.
// A two-entry output stage (register plus skid) keeps req_tready high while
// one rsp item waits; a second waiting item drops req_tready until the
// receiver takes one.
// The csr port is always ready; write it only while the sequencer is idle.
// Reset returns the registers to their defaults, both lines released, the
// sequencer idle, ack_received at one and the output stage empty.
module i2c_master_bit_engine_core
   import i2cbe_pkg::*;
#(
   parameter int unsigned DELAY_BITS = DELAY_BITS_DFLT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Tick channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // cmd_valid, tx_byte[7:0], send_ack, sda_in
   input  logic [1:0]            req_tuser,  // kind[1:0]
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // scl_out, sda_out, busy_res, done_res,
                                             // rx_byte[7:0], ack_received
   // Register write port
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   `include "i2c_master_bit_engine_core_defines.svh"

   localparam logic [31:0] WAIT_MAX = 32'hFFFF_FFFF >> (32 - DELAY_BITS);

   // Clamp a microsecond count to the wait counter range
   function automatic logic [DELAY_BITS-1:0] sat_wait(input logic [15:0] us);
      logic [31:0] us32;
      us32 = 32'(us);
      if (us32 > WAIT_MAX) begin
         return WAIT_MAX[DELAY_BITS-1:0];
      end
      return us32[DELAY_BITS-1:0];
   endfunction

   // Registers
   logic [7:0]  ticks_per_us_ff;
   logic [15:0] cond_hold_ff;
   logic [15:0] wr_setup_ff;
   logic [15:0] wr_high_ff;
   logic [15:0] wr_after_ff;
   logic [15:0] rd_release_ff;
   logic [15:0] rd_high_ff;
   logic [15:0] rd_after_ff;

   // Sequencer state
   phase_type             phase_ff,     phase_in;
   kind_type              op_kind_ff,   op_kind_in;
   logic [3:0]            bit_index_ff, bit_index_in;
   logic [7:0]            shift_ff,     shift_in;
   logic                  ack_choice_ff, ack_choice_in;
   logic [DELAY_BITS-1:0] wait_ff,      wait_in;
   logic [7:0]            prescale_ff,  prescale_in;
   logic                  scl_ff,       scl_in;
   logic                  sda_ff,       sda_in;
   logic [7:0]            rx_ff,        rx_in;
   logic                  ack_ff,       ack_in;

   // Output stage
   logic        out_valid_ff,  out_valid_in;
   logic [15:0] out_data_ff,   out_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [15:0] skid_data_ff,  skid_data_in;

   // Request fields
   logic     cmd_valid;
   kind_type kind;
   logic [7:0] tx_byte;
   logic     send_ack;
   logic     line_sda;

   logic        push;
   logic        pop;
   logic        done_c;
   logic [15:0] result_c;
   logic [7:0]  tick_limit;
   logic [8:0]  prescale_inc;

   assign cmd_valid = req_tdata[0];
   assign tx_byte   = req_tdata[8:1];
   assign send_ack  = req_tdata[9];
   assign line_sda  = req_tdata[10];
   assign kind      = kind_type'(req_tuser);

   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign csr_ready  = 1'b1;

   assign tick_limit   = (ticks_per_us_ff == 8'd0) ? 8'd1 : ticks_per_us_ff;
   assign prescale_inc = {1'b0, prescale_ff} + 9'd1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_per_us_ff <= RST_TICKS_PER_US;
         cond_hold_ff    <= RST_COND_HOLD_US;
         wr_setup_ff     <= RST_WR_SETUP_US;
         wr_high_ff      <= RST_WR_HIGH_US;
         wr_after_ff     <= RST_WR_AFTER_US;
         rd_release_ff   <= RST_RD_RELEASE_US;
         rd_high_ff      <= RST_RD_HIGH_US;
         rd_after_ff     <= RST_RD_AFTER_US;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_TICKS_PER_US:  ticks_per_us_ff <= csr_data[7:0];
            CSR_COND_HOLD_US:  cond_hold_ff    <= csr_data;
            CSR_WR_SETUP_US:   wr_setup_ff     <= csr_data;
            CSR_WR_HIGH_US:    wr_high_ff      <= csr_data;
            CSR_WR_AFTER_US:   wr_after_ff     <= csr_data;
            CSR_RD_RELEASE_US: rd_release_ff   <= csr_data;
            CSR_RD_HIGH_US:    rd_high_ff      <= csr_data;
            CSR_RD_AFTER_US:   rd_after_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Advance the sequencer by one tick
   always_comb begin
      logic      enter_c;
      phase_type enter_ph;
      logic      rd;
      logic      wr_bit;
      logic      is_start;

      phase_in      = phase_ff;
      op_kind_in    = op_kind_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      ack_choice_in = ack_choice_ff;
      wait_in       = wait_ff;
      prescale_in   = prescale_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      rx_in         = rx_ff;
      ack_in        = ack_ff;
      done_c        = 1'b0;
      enter_c       = 1'b0;
      enter_ph      = PH_IDLE;

      if (phase_ff == PH_IDLE) begin
         // Take a command
         if (cmd_valid) begin
            op_kind_in    = kind;
            bit_index_in  = 4'd0;
            ack_choice_in = send_ack;
            shift_in      = (kind == KIND_WRITE) ? tx_byte : 8'd0;
            enter_c       = 1'b1;
            enter_ph      = (kind == KIND_START || kind == KIND_STOP) ? PH_C0 : PH_BSET;
         end
      end else if (wait_ff != '0) begin
         // Count down the current step
         if (prescale_inc >= {1'b0, tick_limit}) begin
            prescale_in = 8'd0;
            wait_in     = wait_ff - DELAY_BITS'(1);
         end else begin
            prescale_in = prescale_inc[7:0];
         end
      end else begin
         // Step done: move to the next one
         case (phase_ff)
            PH_C0: begin
               enter_c  = 1'b1;
               enter_ph = PH_C1;
            end
            PH_C1: begin
               enter_c  = 1'b1;
               enter_ph = PH_C2;
            end
            PH_BSET: begin
               enter_c  = 1'b1;
               enter_ph = PH_BHIGH;
            end
            PH_BHIGH: begin
               if (op_kind_ff == KIND_WRITE) begin
                  if (bit_index_ff >= ACK_BIT_IDX) begin
                     ack_in = line_sda;
                  end
               end else if (bit_index_ff < ACK_BIT_IDX) begin
                  shift_in = {shift_ff[6:0], line_sda};
               end
               enter_c  = 1'b1;
               enter_ph = PH_BLOW;
            end
            PH_BLOW: begin
               bit_index_in = bit_index_ff + 4'd1;
               if (bit_index_in <= ACK_BIT_IDX) begin
                  enter_c  = 1'b1;
                  enter_ph = PH_BSET;
               end else begin
                  if (op_kind_ff == KIND_READ) begin
                     rx_in = shift_ff;
                  end
                  bit_index_in = 4'd0;
                  phase_in     = PH_IDLE;
                  done_c       = 1'b1;
               end
            end
            default: begin
               // Last condition step, or nothing to do
               phase_in = PH_IDLE;
               done_c   = 1'b1;
            end
         endcase
      end

      // Enter a step: set lines and load its wait
      is_start = (op_kind_in == KIND_START);
      rd       = (op_kind_in == KIND_WRITE) ? (bit_index_in >= ACK_BIT_IDX)
                                            : (bit_index_in < ACK_BIT_IDX);
      wr_bit   = (op_kind_in == KIND_WRITE) ? shift_in[3'(LAST_DATA_BIT - bit_index_in)]
                                            : !ack_choice_in;
      if (enter_c) begin
         phase_in    = enter_ph;
         prescale_in = 8'd0;
         case (enter_ph)
            PH_C0: begin
               if (is_start) begin
                  sda_in = 1'b1;
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b0;
               end
               wait_in = sat_wait(cond_hold_ff);
            end
            PH_C1: begin
               if (is_start) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b1;
               end
               wait_in = sat_wait(cond_hold_ff);
            end
            PH_C2: begin
               if (is_start) begin
                  scl_in = 1'b0;
               end else begin
                  sda_in = 1'b1;
               end
               wait_in = sat_wait(cond_hold_ff);
            end
            PH_BSET: begin
               sda_in  = rd ? 1'b1 : wr_bit;
               wait_in = sat_wait(rd ? rd_release_ff : wr_setup_ff);
            end
            PH_BHIGH: begin
               scl_in  = 1'b1;
               wait_in = sat_wait(rd ? rd_high_ff : wr_high_ff);
            end
            PH_BLOW: begin
               scl_in  = 1'b0;
               wait_in = sat_wait(rd ? rd_after_ff : wr_after_ff);
            end
            default: ;
         endcase
      end

      result_c = {3'b000, ack_in, rx_in, done_c, (phase_in != PH_IDLE), sda_in, scl_in};
   end

   // Hold sequencer state between accepted items
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         op_kind_ff    <= KIND_START;
         bit_index_ff  <= 4'd0;
         shift_ff      <= 8'd0;
         ack_choice_ff <= 1'b0;
         wait_ff       <= '0;
         prescale_ff   <= 8'd0;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rx_ff         <= 8'd0;
         ack_ff        <= 1'b1;
      end else if (push) begin
         phase_ff      <= phase_in;
         op_kind_ff    <= op_kind_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         ack_choice_ff <= ack_choice_in;
         wait_ff       <= wait_in;
         prescale_ff   <= prescale_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         rx_ff         <= rx_in;
         ack_ff        <= ack_in;
      end
   end

   // Output register with skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = result_c;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = result_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   // Checks
   `I2CBE_ASSERT_NOW(a_skid_behind_out, skid_valid_ff, out_valid_ff,
      "skid entry holds an item while the output register is empty")
   `I2CBE_ASSERT_NEXT(a_stall_fills_skid, push && out_valid_ff && !rsp_tready,
      skid_valid_ff, "item accepted during a stall was not kept in the skid entry")
   `I2CBE_ASSERT_NEXT(a_done_goes_idle, push && done_c, phase_ff == PH_IDLE,
      "sequencer not idle after a done pulse")
   `I2CBE_ASSERT_NOW(a_prescale_range, phase_ff != PH_IDLE, prescale_ff < tick_limit,
      "prescale count reached the tick limit while busy")

endmodule
